[src/media_slice_reassembly_tracker_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the slice reassembly tracker.
// ----------------------------------------------------------------------------
`ifndef MEDIA_SLICE_REASSEMBLY_TRACKER_CORE_ASSERT_SVH
`define MEDIA_SLICE_REASSEMBLY_TRACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define MSRT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MSRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) else $error(msg);
`else
`define MSRT_ASSERT(label, clk, rstn, prop, msg)
`define MSRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

[src/msrt_pkg.sv]
// ----------------------------------------------------------------------------
// msrt_pkg
// Types and constants of the slice reassembly tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package msrt_pkg;

    localparam logic [23:0] MARK_PLAIN   = 24'h4B514E;
    localparam logic [23:0] MARK_KEY     = 24'h4B514B;
    localparam int          HEADER_BYTES = 19;
    localparam logic [19:0] FILL_MAX     = 20'hFFFFF;

    localparam logic [3:0] ST_STORED    = 4'd0;
    localparam logic [3:0] ST_MISMATCH  = 4'd1;
    localparam logic [3:0] ST_BAD_MARK  = 4'd2;
    localparam logic [3:0] ST_TOO_OLD   = 4'd3;
    localparam logic [3:0] ST_NO_SLOT   = 4'd4;
    localparam logic [3:0] ST_BAD_TRACK = 4'd5;
    localparam logic [3:0] ST_READ_OK   = 4'd6;
    localparam logic [3:0] ST_READ_NRDY = 4'd7;
    localparam logic [3:0] ST_OFF_RANGE = 4'd8;

    localparam logic [1:0] REG_STALE  = 2'd0;
    localparam logic [1:0] REG_LAG    = 2'd1;
    localparam logic [1:0] REG_REUSE  = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [23:0] marker;
        logic [1:0]  track_number;
        logic [30:0] sequence_req;
        logic [18:0] fragment_offset;
        logic [19:0] total_size;
        logic [15:0] packet_length;
    } t_request;

    typedef struct packed {
        logic [3:0]  status;
        logic [4:0]  slot_index;
        logic [18:0] byte_offset;
        logic [19:0] byte_count;
        logic        keyframe_out;
        logic        readjusted;
    } t_result;

    // search broadcast to every cell
    typedef struct packed {
        logic [1:0]         trk;
        logic [30:0]        key_seq;
        logic               key_ok;
        logic signed [32:0] thr;
    } t_query;

    // slot update broadcast, taken by the selected cell
    typedef struct packed {
        logic        we;
        logic        alloc;
        logic [1:0]  trk;
        logic [30:0] seq;
        logic [19:0] total;
        logic        key;
        logic [15:0] payload;
    } t_cmd;

    // match / reusable / complete flags along the chain
    typedef struct packed {
        logic m;
        logic a;
        logic r;
    } t_chain;

endpackage

`default_nettype wire

[src/msrt_if.sv]
// ----------------------------------------------------------------------------
// msrt_in_if / msrt_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface msrt_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [23:0] marker;
    logic [1:0]  track_number;
    logic [30:0] sequence_req;
    logic [18:0] fragment_offset;
    logic [19:0] total_size;
    logic [15:0] packet_length;

    modport source (output valid, opcode, marker, track_number, sequence_req,
                    fragment_offset, total_size, packet_length, input ready);
    modport sink   (input valid, opcode, marker, track_number, sequence_req,
                    fragment_offset, total_size, packet_length, output ready);
endinterface

interface msrt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [4:0]  slot_index;
    logic [18:0] byte_offset;
    logic [19:0] byte_count;
    logic        keyframe_out;
    logic        readjusted;

    modport source (output valid, status, slot_index, byte_offset, byte_count,
                    keyframe_out, readjusted, input ready);
    modport sink   (input valid, status, slot_index, byte_offset, byte_count,
                    keyframe_out, readjusted, output ready);
endinterface

`default_nettype wire

[src/media_slice_reassembly_tracker_core.sv]
// An accepted request passes the states check, scan, pick and commit when the slot
// row is searched; a request rejected at check goes from check straight to commit.
// A new request is taken only in idle, after the last one has committed; the
// commit waits while the output register holds an unaccepted result.
// Reset (synchronous, active low) frees all slots, clears newest and read
// positions and loads the register defaults 7, 5 and 18.
// ----------------------------------------------------------------------------
// media_slice_reassembly_tracker_core
// Per-track slot tracker for slices rebuilt from fragments.
// ----------------------------------------------------------------------------
`default_nettype none
`include "media_slice_reassembly_tracker_core_assert.svh"

module media_slice_reassembly_tracker_core #(
    parameter int TRACKS      = 2,
    parameter int SLOTS       = 20,
    parameter int SLICE_BYTES = 524288
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    msrt_in_if.sink          i_in,
    msrt_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import msrt_pkg::*;

    localparam int TRK_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int IDX_W = $clog2(SLOTS);

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_PICK, S_COMMIT} t_state;

    t_state           r_state;
    t_request         r_req;
    t_result          r_out;
    logic             r_out_valid;
    logic [7:0]       r_stale, r_lag;
    logic [4:0]       r_reuse;
    logic [30:0]      r_newest [TRACKS];
    logic [31:0]      r_rseq   [TRACKS];
    t_query           r_query;
    logic [TRK_W-1:0] r_ti;
    logic             r_fail;
    logic [3:0]       r_fail_code;
    logic [15:0]      r_payload;
    logic [31:0]      r_rs_new;
    logic             r_adj;
    logic [SLOTS-1:0] r_sel;
    logic             r_found, r_alloc;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stale <= 8'd7;
            r_lag   <= 8'd5;
            r_reuse <= 5'd18;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_STALE: r_stale <= pwdata[7:0];
                REG_LAG:   r_lag   <= pwdata[7:0];
                REG_REUSE: r_reuse <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_STALE: prdata = {24'b0, r_stale};
            REG_LAG:   prdata = {24'b0, r_lag};
            REG_REUSE: prdata = {27'b0, r_reuse};
            default:   prdata = '0;
        endcase
    end

    // ---------------- header checks ----------------
    logic               w_trk_ok, w_key, w_too_old, w_off_bad, w_adj;
    logic [1:0]         w_tm1;
    logic [TRK_W-1:0]   w_ti;
    logic [30:0]        w_newest;
    logic signed [32:0] w_nw, w_stale_thr, w_reuse_thr, w_floor;
    logic [15:0]        w_payload;
    logic [20:0]        w_off_sum;
    logic [31:0]        w_rs, w_rs_new;

    always_comb begin
        w_trk_ok    = (r_req.track_number != 2'd0) && (int'(r_req.track_number) <= TRACKS);
        w_tm1       = r_req.track_number - 2'd1;
        w_ti        = w_trk_ok ? w_tm1[TRK_W-1:0] : '0;
        w_key       = (r_req.marker == MARK_KEY);
        w_newest    = r_newest[w_ti];
        w_nw        = $signed({2'b00, w_newest});
        w_stale_thr = w_nw - $signed({25'b0, r_stale});
        w_reuse_thr = w_nw - $signed({28'b0, r_reuse});
        w_floor     = w_nw - $signed({25'b0, r_lag});
        w_payload   = r_req.packet_length - 16'(HEADER_BYTES);
        w_off_sum   = {2'b00, r_req.fragment_offset} + {5'b0, w_payload};
        w_off_bad   = (r_req.packet_length < 16'(HEADER_BYTES)) ||
                      (w_off_sum > 21'(SLICE_BYTES));
        w_too_old   = $signed({2'b00, r_req.sequence_req}) < w_stale_thr;
        w_rs        = r_rseq[w_ti];
        w_adj       = $signed({1'b0, w_rs}) < w_floor;
        w_rs_new    = w_adj ? w_floor[31:0] : w_rs;
    end

    // ---------------- cell row ----------------
    t_cmd        w_cmd;
    t_chain      w_chain [SLOTS+1];
    t_chain      w_first [SLOTS];
    logic [19:0] w_ctot  [SLOTS];
    logic        w_ckey  [SLOTS];

    assign w_chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        msrt_cell #(.TRACKS(TRACKS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_query (r_query),
            .i_cmd   (w_cmd),
            .i_sel   (r_sel[g]),
            .i_chain (w_chain[g]),
            .o_chain (w_chain[g+1]),
            .o_first (w_first[g]),
            .o_tot   (w_ctot[g]),
            .o_key   (w_ckey[g])
        );
    end

    logic [SLOTS-1:0] w_fm, w_fa, w_fr;
    logic [19:0]      w_dtot;
    logic             w_dkey;
    logic [IDX_W-1:0] w_idx;
    logic             w_use_match;

    always_comb begin
        w_dtot = '0;
        w_dkey = 1'b0;
        w_idx  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_fm[i] = w_first[i].m;
            w_fa[i] = w_first[i].a;
            w_fr[i] = w_first[i].r;
            w_dtot  = w_dtot | w_ctot[i];
            w_dkey  = w_dkey | w_ckey[i];
            if (r_sel[i]) begin
                w_idx = w_idx | IDX_W'(i);
            end
        end
        // sequence zero always takes a fresh slot
        w_use_match = w_chain[SLOTS].m && (r_query.key_seq != '0);
    end

    logic w_out_free, w_commit;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_commit   = (r_state == S_COMMIT) && w_out_free;

    always_comb begin
        w_cmd.we      = w_commit && !r_fail && !r_req.opcode && r_found;
        w_cmd.alloc   = r_alloc;
        w_cmd.trk     = r_query.trk;
        w_cmd.seq     = r_req.sequence_req;
        w_cmd.total   = r_req.total_size;
        w_cmd.key     = (r_req.marker == MARK_KEY);
        w_cmd.payload = r_payload;
    end

    t_result n_out;

    always_comb begin
        n_out = '0;
        if (r_fail) begin
            n_out.status = r_fail_code;
        end else if (!r_req.opcode) begin
            if (!r_found) begin
                n_out.status = ST_NO_SLOT;
            end else begin
                n_out.status = (!r_alloc && (r_req.total_size != w_dtot)) ?
                               ST_MISMATCH : ST_STORED;
                n_out.slot_index   = 5'(w_idx);
                n_out.byte_offset  = r_req.fragment_offset;
                n_out.byte_count   = {4'b0, r_payload};
                n_out.keyframe_out = w_cmd.key;
            end
        end else begin
            n_out.readjusted = r_adj;
            if (r_found) begin
                n_out.status       = ST_READ_OK;
                n_out.slot_index   = 5'(w_idx);
                n_out.byte_count   = w_dtot;
                n_out.keyframe_out = w_dkey;
            end else begin
                n_out.status = ST_READ_NRDY;
            end
        end
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sel       <= '0;
            for (int t = 0; t < TRACKS; t++) begin
                r_newest[t] <= '0;
                r_rseq[t]   <= '0;
            end
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_req.opcode          <= i_in.opcode;
                        r_req.marker          <= i_in.marker;
                        r_req.track_number    <= i_in.track_number;
                        r_req.sequence_req    <= i_in.sequence_req;
                        r_req.fragment_offset <= i_in.fragment_offset;
                        r_req.total_size      <= i_in.total_size;
                        r_req.packet_length   <= i_in.packet_length;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_ti            <= w_ti;
                    r_payload       <= w_payload;
                    r_rs_new        <= w_rs_new;
                    r_adj           <= w_adj;
                    r_query.trk     <= 2'(w_ti);
                    if (!r_req.opcode && !w_key && (r_req.marker != MARK_PLAIN)) begin
                        r_fail      <= 1'b1;
                        r_fail_code <= ST_BAD_MARK;
                        r_state     <= S_COMMIT;
                    end else if (!w_trk_ok) begin
                        r_fail      <= 1'b1;
                        r_fail_code <= ST_BAD_TRACK;
                        r_state     <= S_COMMIT;
                    end else if (r_req.opcode) begin
                        r_fail          <= 1'b0;
                        r_query.key_seq <= w_rs_new[30:0];
                        r_query.key_ok  <= !w_rs_new[31];
                        r_query.thr     <= w_reuse_thr;
                        r_state         <= S_SCAN;
                    end else if (w_off_bad) begin
                        r_fail      <= 1'b1;
                        r_fail_code <= ST_OFF_RANGE;
                        r_state     <= S_COMMIT;
                    end else if (w_too_old) begin
                        r_fail      <= 1'b1;
                        r_fail_code <= ST_TOO_OLD;
                        r_state     <= S_COMMIT;
                    end else begin
                        r_fail          <= 1'b0;
                        r_query.key_seq <= r_req.sequence_req;
                        r_query.key_ok  <= 1'b1;
                        r_query.thr     <= w_reuse_thr;
                        r_state         <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (r_req.opcode) begin
                        r_sel   <= w_fr;
                        r_found <= w_chain[SLOTS].r;
                        r_alloc <= 1'b0;
                    end else begin
                        r_sel   <= w_use_match ? w_fm : w_fa;
                        r_found <= w_use_match || w_chain[SLOTS].a;
                        r_alloc <= !w_use_match;
                    end
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (w_out_free) begin
                        r_out       <= n_out;
                        r_sel       <= '0;
                        r_state     <= S_IDLE;
                        if (!r_fail && r_req.opcode) begin
                            r_rseq[r_ti] <= r_found ? r_rs_new + 32'd1 : r_rs_new;
                        end
                        if (w_cmd.we && (r_newest[r_ti] < r_req.sequence_req)) begin
                            r_newest[r_ti] <= r_req.sequence_req;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.slot_index   = r_out.slot_index;
    assign o_out.byte_offset  = r_out.byte_offset;
    assign o_out.byte_count   = r_out.byte_count;
    assign o_out.keyframe_out = r_out.keyframe_out;
    assign o_out.readjusted   = r_out.readjusted;

    // ---------------- assertions ----------------
    `MSRT_ASSERT(a_sel_onehot, i_clk, i_rst_n, $onehot0(r_sel), "slot select not one-hot")
    `MSRT_ASSERT_NEXT(a_pick_commit, i_clk, i_rst_n, (r_state == S_PICK), (r_state == S_COMMIT), "pick not followed by commit")
    `MSRT_ASSERT(a_readj_read, i_clk, i_rst_n, (!r_out_valid || !r_out.readjusted || r_out.status == ST_READ_OK || r_out.status == ST_READ_NRDY), "readjust flag on non-read transaction")

endmodule

`default_nettype wire

[src/msrt_cell.sv]
// ----------------------------------------------------------------------------
// msrt_cell
// One slot position for every track, with its link in the priority chain.
// ----------------------------------------------------------------------------
`default_nettype none

module msrt_cell #(
    parameter int TRACKS = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  msrt_pkg::t_query     i_query,
    input  msrt_pkg::t_cmd       i_cmd,
    input  wire logic            i_sel,
    input  msrt_pkg::t_chain     i_chain,
    output msrt_pkg::t_chain     o_chain,
    output msrt_pkg::t_chain     o_first,
    output logic [19:0]          o_tot,
    output logic                 o_key
);
    import msrt_pkg::*;

    localparam int TRK_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    logic [TRACKS-1:0] r_vld;
    logic [30:0]       r_seq [TRACKS];
    logic [19:0]       r_tot [TRACKS];
    logic [19:0]       r_fil [TRACKS];
    logic              r_key [TRACKS];
    t_chain            r_flag;

    logic [TRK_W-1:0]  w_qt, w_ct;
    logic [30:0]       w_seq;
    logic [19:0]       w_tot, w_fil, w_cfil, w_base;
    logic              w_key;
    logic [20:0]       w_sum;
    t_chain            n_flag;

    assign w_qt = i_query.trk[TRK_W-1:0];
    assign w_ct = i_cmd.trk[TRK_W-1:0];

    // an entry never written reads as zero (free)
    assign w_seq  = r_vld[w_qt] ? r_seq[w_qt] : '0;
    assign w_tot  = r_vld[w_qt] ? r_tot[w_qt] : '0;
    assign w_fil  = r_vld[w_qt] ? r_fil[w_qt] : '0;
    assign w_key  = r_vld[w_qt] ? r_key[w_qt] : 1'b0;
    assign w_cfil = r_vld[w_ct] ? r_fil[w_ct] : '0;

    always_comb begin
        n_flag.m = i_query.key_ok && (w_seq == i_query.key_seq);
        n_flag.a = (w_seq == '0) || ($signed({2'b00, w_seq}) < i_query.thr);
        n_flag.r = n_flag.m && (w_fil == w_tot);
    end

    assign w_base = i_cmd.alloc ? '0 : w_cfil;
    assign w_sum  = {1'b0, w_base} + {5'b0, i_cmd.payload};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_flag <= '0;
        end else begin
            r_flag <= n_flag;
            if (i_cmd.we && i_sel) begin
                r_vld[w_ct] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we && i_sel) begin
            r_fil[w_ct] <= w_sum[20] ? FILL_MAX : w_sum[19:0];
            r_key[w_ct] <= i_cmd.key;
            if (i_cmd.alloc) begin
                r_seq[w_ct] <= i_cmd.seq;
                r_tot[w_ct] <= i_cmd.total;
            end
        end
    end

    always_comb begin
        o_chain.m = i_chain.m | r_flag.m;
        o_chain.a = i_chain.a | r_flag.a;
        o_chain.r = i_chain.r | r_flag.r;
        o_first.m = r_flag.m & ~i_chain.m;
        o_first.a = r_flag.a & ~i_chain.a;
        o_first.r = r_flag.r & ~i_chain.r;
    end

    assign o_tot = i_sel ? w_tot : '0;
    assign o_key = i_sel & w_key;

endmodule

`default_nettype wire

[sim/media_slice_reassembly_tracker_core_tb.sv]
// ----------------------------------------------------------------------------
// media_slice_reassembly_tracker_core_tb
// Drives fragment writes and slice reads through the request channel, writes
// the three registers between phases over APB and checks every result
// against a slot table kept in the scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

import msrt_pkg::*;

class slice_scoreboard;
    localparam int NTRK = 2;
    localparam int NSLOT = 20;
    localparam int SLICE_MAX = 524288;

    bit [30:0] tab_seq [NTRK][NSLOT];
    bit [19:0] tab_total [NTRK][NSLOT];
    bit [19:0] tab_fill [NTRK][NSLOT];
    bit        tab_key [NTRK][NSLOT];
    bit [30:0] newest [NTRK];
    bit [31:0] rd_pos [NTRK];
    bit [7:0]  stale_window = 8'd7;
    bit [7:0]  lag_limit = 8'd5;
    bit [4:0]  reuse_margin = 5'd18;
    t_result   pending_q [$];
    int        errors;

    function void set_reg(logic [1:0] idx, bit [31:0] val);
        case (idx)
            REG_STALE: stale_window = val[7:0];
            REG_LAG:   lag_limit = val[7:0];
            REG_REUSE: reuse_margin = val[4:0];
            default: ;
        endcase
    endfunction

    function t_result predict(t_request r);
        t_result res;
        bit key;
        int t, s, payload;
        longint lim;
        bit [20:0] fill;
        res = '0;
        key = 0;
        if (!r.opcode) begin
            if (r.marker == MARK_KEY) key = 1;
            else if (r.marker != MARK_PLAIN) begin
                res.status = ST_BAD_MARK;
                return res;
            end
        end
        if (r.track_number < 1 || r.track_number > NTRK) begin
            res.status = ST_BAD_TRACK;
            return res;
        end
        t = r.track_number - 1;
        if (r.opcode) begin
            lim = longint'(newest[t]) - longint'(lag_limit);
            if (longint'(rd_pos[t]) < lim) begin
                rd_pos[t] = lim[31:0];
                res.readjusted = 1;
            end
            for (s = 0; s < NSLOT; s++)
                if ({1'b0, tab_seq[t][s]} == rd_pos[t] && tab_fill[t][s] == tab_total[t][s])
                    break;
            if (s == NSLOT) begin
                res.status = ST_READ_NRDY;
                return res;
            end
            rd_pos[t] = rd_pos[t] + 1;
            res.status = ST_READ_OK;
            res.slot_index = s[4:0];
            res.byte_count = tab_total[t][s];
            res.keyframe_out = tab_key[t][s];
            return res;
        end
        if (r.packet_length < HEADER_BYTES) begin
            res.status = ST_OFF_RANGE;
            return res;
        end
        payload = r.packet_length - HEADER_BYTES;
        if (int'(r.fragment_offset) + payload > SLICE_MAX) begin
            res.status = ST_OFF_RANGE;
            return res;
        end
        if (longint'(r.sequence_req) < longint'(newest[t]) - longint'(stale_window)) begin
            res.status = ST_TOO_OLD;
            return res;
        end
        for (s = 0; s < NSLOT; s++)
            if (tab_seq[t][s] == r.sequence_req) break;
        if (s == NSLOT || r.sequence_req == 0) begin
            for (s = 0; s < NSLOT; s++)
                if (tab_seq[t][s] == 0 || longint'(tab_seq[t][s]) <
                    longint'(newest[t]) - longint'(reuse_margin))
                    break;
            if (s == NSLOT) begin
                res.status = ST_NO_SLOT;
                return res;
            end
            tab_total[t][s] = r.total_size;
            tab_fill[t][s] = '0;
            tab_seq[t][s] = r.sequence_req;
        end
        res.status = (r.total_size != tab_total[t][s]) ? ST_MISMATCH : ST_STORED;
        tab_key[t][s] = key;
        fill = tab_fill[t][s] + payload;
        tab_fill[t][s] = (fill > FILL_MAX) ? FILL_MAX : fill[19:0];
        if (newest[t] < r.sequence_req) newest[t] = r.sequence_req;
        res.slot_index = s[4:0];
        res.byte_offset = r.fragment_offset;
        res.byte_count = payload[19:0];
        res.keyframe_out = key;
        return res;
    endfunction

    function void note_request(t_request r);
        pending_q.push_back(predict(r));
    endfunction

    function void flag(string what, longint unsigned exp_v, longint unsigned act_v);
        errors++;
        if (errors <= 10)
            $display("%0t: %s expected %0h got %0h", $realtime, what, exp_v, act_v);
    endfunction

    function void check_result(t_result act);
        t_result exp_r;
        if (pending_q.size() == 0) begin
            flag("unexpected result, status", 0, act.status);
            return;
        end
        exp_r = pending_q.pop_front();
        if (exp_r.status !== act.status) flag("status", exp_r.status, act.status);
        if (exp_r.slot_index !== act.slot_index)
            flag("slot_index", exp_r.slot_index, act.slot_index);
        if (exp_r.byte_offset !== act.byte_offset)
            flag("byte_offset", exp_r.byte_offset, act.byte_offset);
        if (exp_r.byte_count !== act.byte_count)
            flag("byte_count", exp_r.byte_count, act.byte_count);
        if (exp_r.keyframe_out !== act.keyframe_out)
            flag("keyframe_out", exp_r.keyframe_out, act.keyframe_out);
        if (exp_r.readjusted !== act.readjusted)
            flag("readjusted", exp_r.readjusted, act.readjusted);
    endfunction
endclass

module media_slice_reassembly_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    msrt_in_if  in_if();
    msrt_out_if out_if();

    media_slice_reassembly_tracker_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_if), .o_out(out_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    slice_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;
    int hold_cnt = 0;
    bit hold_req = 0;
    int stall_mode = 0;
    int mode_left = 0;
    bit [30:0] seq_base [2];

    initial begin
        in_if.valid = 0;
        in_if.opcode = 0;
        in_if.marker = '0;
        in_if.track_number = '0;
        in_if.sequence_req = '0;
        in_if.fragment_offset = '0;
        in_if.total_size = '0;
        in_if.packet_length = '0;
        out_if.ready = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("media_slice_reassembly_tracker_core: mismatch");
            $finish;
        end
    end

    // result side: check accepted transactions, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_result({out_if.status, out_if.slot_index, out_if.byte_offset,
                             out_if.byte_count, out_if.keyframe_out, out_if.readjusted});
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 0;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 80);
        end else
            mode_left--;
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_if.ready <= 0;
        end else if (stall_mode == 0)
            out_if.ready <= 1;
        else if (stall_mode == 1)
            out_if.ready <= ($urandom_range(0, 3) != 0);
        else
            out_if.ready <= ($urandom_range(0, 3) == 0);
    end

    task automatic send_request(t_request r);
        int gap;
        in_if.valid <= 1;
        in_if.opcode <= r.opcode;
        in_if.marker <= r.marker;
        in_if.track_number <= r.track_number;
        in_if.sequence_req <= r.sequence_req;
        in_if.fragment_offset <= r.fragment_offset;
        in_if.total_size <= r.total_size;
        in_if.packet_length <= r.packet_length;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_request(r);
        if (burst_left > 0)
            burst_left--;
        else begin
            burst_left = $urandom_range(0, 20);
            gap = $urandom_range(1, 8);
            in_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, bit [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic set_regs(bit [31:0] stale, bit [31:0] lag, bit [31:0] reuse);
        drain_results();
        apb_write(REG_STALE, stale);
        apb_write(REG_LAG, lag);
        apb_write(REG_REUSE, reuse);
    endtask

    function automatic t_request rand_request();
        return t_request'(113'({$urandom, $urandom, $urandom, $urandom}));
    endfunction

    function automatic t_request frag(int trk, bit [30:0] seq, int off, int total,
                                      int plen, bit key);
        t_request r;
        r.opcode = 0;
        r.marker = key ? MARK_KEY : MARK_PLAIN;
        r.track_number = trk[1:0];
        r.sequence_req = seq;
        r.fragment_offset = off[18:0];
        r.total_size = total[19:0];
        r.packet_length = plen[15:0];
        return r;
    endfunction

    function automatic t_request read_req(int trk);
        t_request r;
        r = rand_request();
        r.opcode = 1;
        r.track_number = trk[1:0];
        return r;
    endfunction

    task automatic directed_items();
        t_request r;
        send_request(read_req(1));              // read at position zero
        send_request(read_req(2));
        r = frag(1, 5, 0, 10, 29, 0);
        r.marker = 24'h4B514C;
        send_request(r);                        // bad marker
        send_request(frag(0, 5, 0, 10, 29, 0)); // bad track
        send_request(frag(3, 5, 0, 10, 29, 1));
        send_request(read_req(3));
        send_request(frag(1, 5, 0, 10, 18, 0)); // short datagram
        send_request(frag(1, 5, 524287, 10, 100, 0));
        send_request(frag(1, 5, 524287, 10, 20, 0));
        send_request(frag(1, 0, 0, 10, 29, 0)); // sequence zero
        send_request(frag(1, 0, 0, 10, 29, 1));
        send_request(frag(1, 5, 0, 100, 119, 1));
        send_request(frag(1, 5, 0, 50, 19, 0)); // size mismatch
        send_request(frag(1, 20, 0, 0, 19, 0));
        send_request(frag(1, 2, 0, 0, 19, 0));  // too old
        send_request(read_req(1));              // pulled forward, not ready
        send_request(frag(1, 15, 0, 0, 19, 1));
        send_request(read_req(1));
        send_request(frag(2, 3, 0, 524288, 65535, 1));
        send_request(frag(2, 3, 65516, 524288, 65535, 0));
        send_request(read_req(2));
        send_request(read_req(2));
    endtask

    task automatic random_items(int count, bit do_hold);
        int n, kind, trk, tot, a;
        bit [30:0] seq;
        t_request r;
        n = 0;
        while (n < count) begin
            if (do_hold && n == count / 2) begin
                hold_req = 1;
                do_hold = 0;
            end
            kind = $urandom_range(0, 99);
            trk = $urandom_range(1, 2);
            if (kind < 55) begin
                if ($urandom_range(0, 3) == 0) seq_base[trk-1] += $urandom_range(1, 3);
                seq = seq_base[trk-1] + $urandom_range(0, 4);
                tot = $urandom_range(0, 3) == 0 ? $urandom_range(0, 524288)
                                                : $urandom_range(0, 3000);
                a = (tot > 65516) ? 65516 : $urandom_range(0, tot);
                send_request(frag(trk, seq, 0, tot, a + 19, $urandom_range(0, 1)));
                if ($urandom_range(0, 9) != 0 && tot - a <= 65516) begin
                    if ($urandom_range(0, 19) == 0) tot = tot + 1;
                    send_request(frag(trk, seq, a, tot, tot - a + 19, $urandom_range(0, 1)));
                    n++;
                end
            end else if (kind < 80)
                send_request(read_req(trk));
            else if (kind < 90) begin
                r = rand_request();
                if ($urandom_range(0, 1)) r.marker = MARK_PLAIN;
                if (r.track_number inside {2'd1, 2'd2}) r.track_number = 0;
                send_request(r);
            end else if (kind < 95) begin
                seq = $urandom_range(0, 1) ? 31'd0 : seq_base[trk-1] - $urandom_range(0, 30);
                send_request(frag(trk, seq, $urandom, $urandom_range(0, 2000),
                                  $urandom_range(0, 70000), $urandom_range(0, 1)));
            end else begin
                send_request(frag(trk, seq_base[trk-1] + $urandom_range(0, 40),
                                  $urandom_range(0, 524287), $urandom_range(0, 4000),
                                  $urandom_range(0, 65535), $urandom_range(0, 1)));
            end
            n++;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        directed_items();
        seq_base[0] = 40;
        seq_base[1] = 40;
        random_items(250, 1);
        set_regs(0, 0, 0);
        random_items(250, 0);
        set_regs(255, 255, 20);
        seq_base[0] = 31'h100000;
        seq_base[1] = 31'h0ABCDE;
        random_items(300, 0);
        // saturate one slot's fill
        drain_results();
        repeat (17) send_request(frag(1, seq_base[0] + 1, 0, 1000, 65535, 1));
        set_regs($urandom_range(1, 254), $urandom_range(1, 254), $urandom_range(1, 19));
        seq_base[0] = 31'h55555555;
        seq_base[1] = 31'h2AAAAAAA;
        random_items(300, 1);
        set_regs(3, 2, 1);
        seq_base[0] = 31'h7FFFF000;
        seq_base[1] = 31'h7FFFF000;
        random_items(300, 0);
        drain_results();
        if (sb.errors == 0)
            $display("media_slice_reassembly_tracker_core: match");
        else
            $display("media_slice_reassembly_tracker_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+src
src/msrt_pkg.sv
src/msrt_if.sv
src/msrt_cell.sv
src/media_slice_reassembly_tracker_core.sv
sim/media_slice_reassembly_tracker_core_tb.sv
